FILE: src/uud_pkg.sv
// Shared types, codes and the standard character table of the uudecode line decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package uud_pkg;

	// Table size default and the queue depth
	localparam int TABLE_ENTRIES_DEF = 256;
	localparam int QUEUE_DEPTH       = 4;

	// Characters of the standard mapping
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_LAST_STD  = 8'h5F;
	localparam logic [7:0] CH_BACKQUOTE = 8'h60;
	localparam logic [7:0] CH_CARET     = 8'h5E;
	localparam logic [7:0] CH_TILDE     = 8'h7E;

	// Input word actions
	localparam logic [1:0] ACT_CHAR  = 2'd0;
	localparam logic [1:0] ACT_EOL   = 2'd1;
	localparam logic [1:0] ACT_WRITE = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	// Result word kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_SHORT = 2'd2;

	// One classified line event between front and back
	typedef struct packed {
		logic       eol;
		logic [5:0] sextet;
	} uud_qent_t;

	// Queue fill status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} uud_qstat_t;

	// Standard mapping: space..underscore give 0..63, backquote as space, tilde as caret
	function automatic logic [5:0] std_sextet(input logic [7:0] c);
		logic [5:0] v;
		v = 6'd0;
		if (c >= CH_SPACE && c <= CH_LAST_STD)
			v = 6'(c - CH_SPACE);
		else if (c == CH_BACKQUOTE)
			v = 6'd0;
		else if (c == CH_TILDE)
			v = 6'(CH_CARET - CH_SPACE);
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: src/uud_front.sv
// Front end: accepts input words, keeps the character table and turns characters into sextets.
// Depends on uud_pkg; feeds uud_queue.
`default_nettype none

module uud_front
	import uud_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] action,
	input  wire logic [7:0] char_code,
	input  wire logic [5:0] table_value,
	output logic            push_valid,
	output uud_qent_t       push_entry,
	input  wire uud_qstat_t q_stat
);

	localparam int         IDX_W = $clog2(TABLE_ENTRIES);
	localparam logic [8:0] LIMIT = 9'(TABLE_ENTRIES);

	logic [5:0]               tbl_mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] written_q;
	logic                     zero_base_q;

	logic                     valid_s1;
	logic                     eol_s1;
	logic                     in_range_s1;
	logic                     hit_s1;
	logic                     zero_s1;
	logic [7:0]               code_s1;
	logic [5:0]               rd_s1;

	logic                     accept;
	logic                     in_range;
	logic [IDX_W-1:0]         idx;
	logic                     is_line;
	logic                     pushed;

	assign accept   = in_valid && in_ready;
	assign in_range = {1'b0, char_code} < LIMIT;
	assign idx      = char_code[IDX_W-1:0];
	assign is_line  = (action == ACT_CHAR) || (action == ACT_EOL);
	assign pushed   = valid_s1 && !q_stat.full;
	assign in_ready = !valid_s1 || !q_stat.full;

	// Table memory: at most one write or one registered read per accepted word
	always_ff @(posedge clk) begin
		if (accept && action == ACT_WRITE && in_range)
			tbl_mem[idx] <= table_value;
		if (accept && action == ACT_CHAR && in_range)
			rd_s1 <= tbl_mem[idx];
	end

	// Hold the stage payload with the table state it must see
	always_ff @(posedge clk) begin
		if (accept && is_line) begin
			eol_s1      <= (action == ACT_EOL);
			code_s1     <= char_code;
			in_range_s1 <= in_range;
			hit_s1      <= in_range && written_q[idx];
			zero_s1     <= zero_base_q;
		end
	end

	// Track written entries and the base contents behind unwritten ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q   <= '0;
			zero_base_q <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			if (accept && action == ACT_CLEAR) begin
				written_q   <= '0;
				zero_base_q <= 1'b1;
			end else if (accept && action == ACT_WRITE && in_range) begin
				written_q[idx] <= 1'b1;
			end
			if (accept && is_line)
				valid_s1 <= 1'b1;
			else if (pushed)
				valid_s1 <= 1'b0;
		end
	end

	// Resolve the sextet: zero out of range, else written entry, cleared base or standard mapping
	always_comb begin
		push_entry.eol = eol_s1;
		if (!in_range_s1)
			push_entry.sextet = 6'd0;
		else if (hit_s1)
			push_entry.sextet = rd_s1;
		else if (zero_s1)
			push_entry.sextet = 6'd0;
		else
			push_entry.sextet = std_sextet(code_s1);
	end

	assign push_valid = valid_s1;

endmodule

`default_nettype wire

FILE: src/uud_queue.sv
// Short queue of classified line events between the front and back ends.
// Depends on uud_pkg.
`default_nettype none

module uud_queue
	import uud_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push_valid,
	input  wire uud_qent_t  push_entry,
	input  wire logic       pop,
	output uud_qent_t       pop_entry,
	output uud_qstat_t      q_stat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	uud_qent_t        slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;

	assign q_stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign do_push      = push_valid && !q_stat.full;
	assign pop_entry    = slot_q[rd_ptr_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: src/uud_back.sv
// Back end: line state machine that assembles bytes from sextets and reports line events.
// Depends on uud_pkg; drains uud_queue into the output register.
`default_nettype none

module uud_back
	import uud_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire uud_qstat_t q_stat,
	input  wire uud_qent_t  entry,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      kind,
	output logic [7:0]      data_byte
);

	typedef enum logic [2:0] {
		POS_COUNT,
		POS_G1,
		POS_G2,
		POS_G3,
		POS_G4,
		POS_DRAIN
	} pos_t;

	pos_t       pos_q;
	logic [5:0] owed_q;
	logic [5:0] held_q;
	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] byte_q;

	pos_t       pos_d;
	logic [5:0] owed_d;
	logic [5:0] held_d;
	logic [5:0] owed_dec;
	logic       res_valid;
	logic [1:0] res_kind;
	logic [7:0] res_byte;

	assign pop      = !q_stat.empty && (!out_valid_q || out_ready);
	assign owed_dec = owed_q - 6'd1;

	// Next line state and result for the word at the head of the queue
	always_comb begin
		pos_d     = pos_q;
		owed_d    = owed_q;
		held_d    = held_q;
		res_valid = 1'b0;
		res_kind  = KIND_DATA;
		res_byte  = 8'd0;
		if (entry.eol) begin
			pos_d  = POS_COUNT;
			owed_d = 6'd0;
			held_d = 6'd0;
			case (pos_q)
				POS_COUNT: begin
					res_valid = 1'b1;
					res_kind  = KIND_END;
				end
				POS_G1, POS_G2, POS_G3, POS_G4: begin
					res_valid = 1'b1;
					res_kind  = KIND_SHORT;
				end
				default: res_valid = 1'b0;
			endcase
		end else begin
			case (pos_q)
				POS_COUNT: begin
					if (entry.sextet == 6'd0) begin
						pos_d     = POS_DRAIN;
						owed_d    = 6'd0;
						res_valid = 1'b1;
						res_kind  = KIND_END;
					end else begin
						owed_d = entry.sextet;
						pos_d  = POS_G1;
					end
				end
				POS_G1: begin
					held_d = entry.sextet;
					pos_d  = POS_G2;
				end
				POS_G2, POS_G3, POS_G4: begin
					res_valid = 1'b1;
					held_d    = entry.sextet;
					owed_d    = owed_dec;
					if (pos_q == POS_G2) begin
						res_byte = {held_q, entry.sextet[5:4]};
						pos_d    = POS_G3;
					end else if (pos_q == POS_G3) begin
						res_byte = {held_q[3:0], entry.sextet[5:2]};
						pos_d    = POS_G4;
					end else begin
						res_byte = {held_q[1:0], entry.sextet};
						pos_d    = POS_G1;
					end
					if (owed_dec == 6'd0)
						pos_d = POS_DRAIN;
				end
				default: pos_d = POS_DRAIN;
			endcase
		end
	end

	// Hold line state and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_COUNT;
			owed_q      <= 6'd0;
			held_q      <= 6'd0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_DATA;
			byte_q      <= 8'd0;
		end else begin
			if (pop) begin
				pos_q  <= pos_d;
				owed_q <= owed_d;
				held_q <= held_d;
				if (res_valid) begin
					kind_q <= res_kind;
					byte_q <= res_byte;
				end
				out_valid_q <= res_valid;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign data_byte = byte_q;

endmodule

`default_nettype wire

FILE: src/uudecode_line_decoder.sv
// Top level of the uudecode line decoder: front end, event queue and back end.
// Depends on uud_pkg, uud_front, uud_queue and uud_back.
//
// Takes one word per clock cycle while the front stage is not held by a full queue. Each
// word is a line character, an end of line, a write of one character table entry or a clear
// of the whole table to zeros. Table actions take effect in the cycle they are accepted and
// give no result; characters are looked up in the table (one registered read of the table
// memory) and pass a four-deep queue to the line state machine, which turns the count
// character and groups of four characters into data bytes, reports end of data and short
// lines, and ignores characters past the count. The table starts in the standard uuencode
// mapping straight after reset, with no clearing pass: per-entry written flags select
// between the memory and the base mapping, so a table clear needs no pass either. Each result
// passes the table read register, the queue and the output register.
`default_nettype none

module uudecode_line_decoder
	import uud_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [7:0] char_code, [13:8] table_value, [15:14] zero
	input  wire logic [1:0]  s_axis_tuser,  // [1:0] action
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [7:0] data_byte
	output logic [1:0]       m_axis_tuser   // [1:0] kind
);

	logic       push_valid;
	uud_qent_t  push_entry;
	uud_qent_t  head_entry;
	uud_qstat_t q_stat;
	logic       pop;

	uud_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.action     (s_axis_tuser),
		.char_code  (s_axis_tdata[7:0]),
		.table_value(s_axis_tdata[13:8]),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.q_stat     (q_stat)
	);

	uud_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_entry(push_entry),
		.pop       (pop),
		.pop_entry (head_entry),
		.q_stat    (q_stat)
	);

	uud_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.entry    (head_entry),
		.pop      (pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.kind     (m_axis_tuser),
		.data_byte(m_axis_tdata)
	);

	// Only the three defined kinds leave the block
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == KIND_DATA || m_axis_tuser == KIND_END ||
			m_axis_tuser == KIND_SHORT))
		else $error("undefined result kind");

	// Line events carry a zero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != KIND_DATA) |-> (m_axis_tdata == 8'd0))
		else $error("non-data result with a non-zero byte");

	// The queue is popped only when it holds a word
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from an empty queue");

	// Input is refused only while the front stage waits on a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (q_stat.full && push_valid))
		else $error("input stalled without back-pressure");

endmodule

`default_nettype wire
